@@ hdl/mta_pkg.sv @@
package mta_pkg;

   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 4;
   localparam int DATA_W  = 32;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_CUR  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_OPD  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SCALE     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd5;

   typedef enum logic [2:0] {
      OP_LOAD_CUR,
      OP_LOAD_OPD,
      OP_MUL,
      OP_TRANSLATE,
      OP_SCALE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         index;
      logic signed [DATA_W-1:0]   value;
      logic signed [DATA_W-1:0]   vec_x;
      logic signed [DATA_W-1:0]   vec_y;
      logic signed [DATA_W-1:0]   vec_z;
   } cmd_type;

endpackage

@@ hdl/mta_req_if.sv @@
interface mta_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [mta_pkg::FUNC_W-1:0]              func;
   logic [mta_pkg::INDEX_W-1:0]             index;
   logic signed [mta_pkg::DATA_W-1:0]       value;
   logic signed [mta_pkg::DATA_W-1:0]       vec_x;
   logic signed [mta_pkg::DATA_W-1:0]       vec_y;
   logic signed [mta_pkg::DATA_W-1:0]       vec_z;

   modport source (output valid, func, index, value, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, func, index, value, vec_x, vec_y, vec_z, output ready);
endinterface

@@ hdl/mta_rsp_if.sv @@
interface mta_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [mta_pkg::INDEX_W-1:0]             elem_index;
   logic signed [mta_pkg::DATA_W-1:0]       elem_value;
   logic                                    last;

   modport source (output valid, elem_index, elem_value, last, input ready);
   modport sink   (input valid, elem_index, elem_value, last, output ready);
endinterface

@@ hdl/mta_front.sv @@
module mta_front #(
   parameter int DIM = 4
) (
   mta_req_if.sink           req_bus,
   input  logic              q_full,
   output logic              q_push,
   output mta_pkg::cmd_type  q_cmd
);

   localparam int NELEM = DIM * DIM;

   logic keep;

   // classify: drop unused codes and loads that fall outside the matrix
   always_comb begin
      keep     = 1'b1;
      q_cmd.op = mta_pkg::OP_READ;
      case (req_bus.func)
         mta_pkg::FUNC_LOAD_CUR: begin
            q_cmd.op = mta_pkg::OP_LOAD_CUR;
            keep     = (int'(req_bus.index) < NELEM);
         end
         mta_pkg::FUNC_LOAD_OPD: begin
            q_cmd.op = mta_pkg::OP_LOAD_OPD;
            keep     = (int'(req_bus.index) < NELEM);
         end
         mta_pkg::FUNC_MUL:       q_cmd.op = mta_pkg::OP_MUL;
         mta_pkg::FUNC_TRANSLATE: q_cmd.op = mta_pkg::OP_TRANSLATE;
         mta_pkg::FUNC_SCALE:     q_cmd.op = mta_pkg::OP_SCALE;
         mta_pkg::FUNC_READ:      q_cmd.op = mta_pkg::OP_READ;
         default:                 keep     = 1'b0;
      endcase
      q_cmd.index = req_bus.index;
      q_cmd.value = req_bus.value;
      q_cmd.vec_x = req_bus.vec_x;
      q_cmd.vec_y = req_bus.vec_y;
      q_cmd.vec_z = req_bus.vec_z;
   end

   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full && keep;

endmodule

@@ hdl/mta_queue.sv @@
module mta_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mta_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output mta_pkg::cmd_type  head_cmd,
   output logic              full,
   output logic              empty
);

   mta_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/mta_back.sv @@
module mta_back #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  mta_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   mta_rsp_if.source         rsp_bus
);

   localparam int NELEM = DIM * DIM;
   localparam int IDX_W = $clog2(NELEM);
   localparam int DW    = $clog2(DIM);
   localparam int ACC_W = 64 + DW + 1;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7fffffff);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sh7fffffff - 32'sd1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   mta_pkg::cmd_type        cmd_ff;
   logic signed [31:0]      cur_ff [NELEM];
   logic signed [31:0]      opd_ff [NELEM];
   logic signed [31:0]      rowbuf_ff [DIM];
   logic [DW-1:0]           row_ff, col_ff, k_ff;
   logic signed [63:0]      prod_ff;
   logic                    p_vld_ff, p_first_ff, p_lastk_ff;
   logic [DW-1:0]           p_row_ff, p_col_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] shifted;
   logic signed [31:0]      sat_val;
   logic signed [31:0]      lhs, rhs;
   logic [IDX_W-1:0]        emit_ff;
   logic                    emit_last;
   logic                    rsp_vld_ff;
   logic [3:0]              rsp_idx_ff;
   logic signed [31:0]      rsp_val_ff;
   logic                    rsp_last_ff;
   logic                    emit_load;
   logic                    k_end, c_end, r_end;
   logic [7:0]              emit_wide;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   assign k_end = (int'(k_ff) == DIM - 1);
   assign c_end = (int'(col_ff) == DIM - 1);
   assign r_end = (int'(row_ff) == DIM - 1);

   // right operand element (k, col) for the running operation
   always_comb begin
      logic signed [31:0] vk;
      vk = cmd_ff.vec_x;
      case (int'(k_ff))
         0:       vk = cmd_ff.vec_x;
         1:       vk = cmd_ff.vec_y;
         default: vk = cmd_ff.vec_z;
      endcase
      rhs = '0;
      case (cmd_ff.op)
         mta_pkg::OP_MUL: rhs = opd_ff[IDX_W'(int'(k_ff) * DIM + int'(col_ff))];
         mta_pkg::OP_TRANSLATE: begin
            if (k_ff == col_ff) begin
               rhs = ONE;
            end else if (c_end && int'(k_ff) < 3 && int'(k_ff) < DIM - 1) begin
               rhs = vk;
            end
         end
         mta_pkg::OP_SCALE: begin
            if (k_ff == col_ff) begin
               rhs = (int'(k_ff) < 3 && int'(k_ff) < DIM - 1) ? vk : ONE;
            end
         end
         default: rhs = '0;
      endcase
      lhs = cur_ff[IDX_W'(int'(row_ff) * DIM + int'(k_ff))];
   end

   // floor shift of the exact sum, then clamp to 32 bits
   always_comb begin
      acc_in  = (p_first_ff ? '0 : acc_ff) + ACC_W'(prod_ff);
      shifted = acc_in >>> FRAC_BITS;
      if (shifted > SAT_MAX) begin
         sat_val = 32'sh7fffffff;
      end else if (shifted < SAT_MIN) begin
         sat_val = -32'sh7fffffff - 32'sd1;
      end else begin
         sat_val = 32'(shifted);
      end
   end

   assign emit_load = (state_ff == ST_EMIT) && (!rsp_vld_ff || rsp_bus.ready);
   assign emit_last = (int'(emit_ff) == NELEM - 1);
   assign emit_wide = 8'(emit_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               case (q_cmd.op)
                  mta_pkg::OP_MUL, mta_pkg::OP_TRANSLATE, mta_pkg::OP_SCALE:
                     state_in = ST_MUL;
                  mta_pkg::OP_READ: state_in = ST_EMIT;
                  default:          state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:   if (k_end && c_end && r_end) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT:  if (emit_load && emit_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         p_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         emit_ff    <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         k_ff       <= '0;
      end else begin
         state_ff <= state_in;
         p_vld_ff <= (state_ff == ST_MUL);
         if (q_pop) begin
            row_ff <= '0;
            col_ff <= '0;
            k_ff   <= '0;
         end else if (state_ff == ST_MUL) begin
            // advance k, then column, then row
            k_ff <= k_end ? '0 : k_ff + 1'b1;
            if (k_end) begin
               col_ff <= c_end ? '0 : col_ff + 1'b1;
               if (c_end) begin
                  row_ff <= row_ff + 1'b1;
               end
            end
         end
         if (emit_load) begin
            rsp_vld_ff <= 1'b1;
            emit_ff    <= emit_last ? '0 : emit_ff + 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // matrix storage: identity and zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               cur_ff[r * DIM + c] <= (r == c) ? ONE : '0;
               opd_ff[r * DIM + c] <= '0;
            end
         end
      end else begin
         if (q_pop && q_cmd.op == mta_pkg::OP_LOAD_CUR) begin
            cur_ff[IDX_W'(q_cmd.index)] <= q_cmd.value;
         end
         if (q_pop && q_cmd.op == mta_pkg::OP_LOAD_OPD) begin
            opd_ff[IDX_W'(q_cmd.index)] <= q_cmd.value;
         end
         // write a finished row back; later rows never read it
         if (p_vld_ff && p_lastk_ff && int'(p_col_ff) == DIM - 1) begin
            for (int j = 0; j < DIM; j++) begin
               cur_ff[IDX_W'(int'(p_row_ff) * DIM + j)] <=
                  (j == DIM - 1) ? sat_val : rowbuf_ff[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      prod_ff    <= 64'(lhs) * 64'(rhs);
      p_first_ff <= (k_ff == '0);
      p_lastk_ff <= k_end;
      p_row_ff   <= row_ff;
      p_col_ff   <= col_ff;
      if (p_vld_ff) begin
         acc_ff <= acc_in;
         if (p_lastk_ff) begin
            rowbuf_ff[p_col_ff] <= sat_val;
         end
      end
      if (emit_load) begin
         rsp_idx_ff  <= emit_wide[3:0];
         rsp_val_ff  <= cur_ff[emit_ff];
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.elem_index = rsp_idx_ff;
   assign rsp_bus.elem_value = rsp_val_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

@@ hdl/matrix_transform_accumulator_top.sv @@
// Matrix transform accumulator: holds a current DIM x DIM row-major matrix and
// an operand matrix in signed fixed point (FRAC_BITS fraction bits), both
// cleared at reset to identity and zero. Loads are written when the back end
// pops them and give no response. Multiply, translate and scale run every product
// through one shared 32x32 multiplier, then stream all DIM*DIM elements
// one per cycle while the receiver is ready, with last on the final one;
// read streams at once. Sums are exact, floored by FRAC_BITS and clamped to
// 32 bits. A two-deep command queue lets requests keep arriving while a
// result run is under way. Unused function codes and out-of-range loads are
// dropped on entry.
module matrix_transform_accumulator_top #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mta_req_if.sink    req_bus,
   mta_rsp_if.source  rsp_bus
);

   logic             q_push, q_pop, q_full, q_empty;
   mta_pkg::cmd_type q_in_cmd, q_head_cmd;

   mta_front #(.DIM(DIM)) u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (q_in_cmd)
   );

   mta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .head_cmd (q_head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   mta_back #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (q_head_cmd),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ dv/tb_matrix_transform_accumulator_top.sv @@
module tb_matrix_transform_accumulator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ELEM = 16;
   localparam int FRAC = 16;
   localparam logic [mta_pkg::FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
   localparam logic [mta_pkg::FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
   localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct {
      logic [mta_pkg::INDEX_W-1:0] idx;
      logic signed [31:0]          val;
      logic                        last;
   } elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   mta_req_if req_bus();
   mta_rsp_if rsp_bus();

   matrix_transform_accumulator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic signed [31:0] cur_mat [N_ELEM];
   logic signed [31:0] opd_mat [N_ELEM];
   elem_type           elem_queue[$];
   int                 fail_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // push the whole current matrix as one run of results
   task automatic push_matrix();
      elem_type e;
      for (int i = 0; i < N_ELEM; i++) begin
         e.idx = i[3:0];
         e.val = cur_mat[i];
         e.last = (i == N_ELEM - 1);
         elem_queue.push_back(e);
      end
   endtask

   task automatic post_multiply(input logic signed [31:0] rhs [N_ELEM]);
      logic signed [31:0] res [N_ELEM];
      logic signed [79:0] acc;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int k = 0; k < 4; k++)
               acc += 80'(cur_mat[r*4+k]) * 80'(rhs[k*4+c]);
            acc = acc >>> FRAC;
            if (acc > 80'(S32_MAX)) res[r*4+c] = S32_MAX;
            else if (acc < 80'(S32_MIN)) res[r*4+c] = S32_MIN;
            else res[r*4+c] = acc[31:0];
         end
      end
      cur_mat = res;
   endtask

   task automatic predict(input logic [2:0] func, input logic [3:0] idx,
                          input logic signed [31:0] val, input logic signed [31:0] vx,
                          input logic signed [31:0] vy, input logic signed [31:0] vz);
      logic signed [31:0] tm [N_ELEM];
      foreach (tm[i]) tm[i] = (i % 5 == 0) ? ONE_Q : '0;
      case (func)
         mta_pkg::FUNC_LOAD_CUR: cur_mat[idx] = val;
         mta_pkg::FUNC_LOAD_OPD: opd_mat[idx] = val;
         mta_pkg::FUNC_MUL: begin
            post_multiply(opd_mat);
            push_matrix();
         end
         mta_pkg::FUNC_TRANSLATE: begin
            tm[3] = vx; tm[7] = vy; tm[11] = vz;
            post_multiply(tm);
            push_matrix();
         end
         mta_pkg::FUNC_SCALE: begin
            tm[0] = vx; tm[5] = vy; tm[10] = vz;
            post_multiply(tm);
            push_matrix();
         end
         mta_pkg::FUNC_READ: push_matrix();
         default: ;
      endcase
   endtask

   // leaves valid high on return; the next call or drain settles it
   task automatic send_cmd(input logic [2:0] func, input logic [3:0] idx = '0,
                           input logic signed [31:0] val = '0,
                           input logic signed [31:0] vx = '0,
                           input logic signed [31:0] vy = '0,
                           input logic signed [31:0] vz = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.func = func;
      req_bus.index = idx;
      req_bus.value = val;
      req_bus.vec_x = vx;
      req_bus.vec_y = vy;
      req_bus.vec_z = vz;
      do @(posedge clock); while (!req_bus.ready);
      predict(func, idx, val, vx, vy, vz);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (elem_queue.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_fixed();
      if ($urandom_range(3) == 0) return $urandom;
      return $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
   endfunction

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      elem_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (elem_queue.size() == 0) begin
            report($sformatf("unexpected transfer idx %0d", rsp_bus.elem_index));
         end else begin
            e = elem_queue.pop_front();
            if (rsp_bus.elem_index !== e.idx)
               report($sformatf("elem_index %0d, want %0d", rsp_bus.elem_index, e.idx));
            if (rsp_bus.elem_value !== e.val)
               report($sformatf("elem_value %h at %0d, want %h",
                                rsp_bus.elem_value, e.idx, e.val));
            if (rsp_bus.last !== e.last)
               report($sformatf("last %b at %0d, want %b", rsp_bus.last, e.idx, e.last));
         end
      end
   end

   task automatic test_reset_state();
      send_cmd(mta_pkg::FUNC_READ);
      send_cmd(mta_pkg::FUNC_MUL);
      drain();
   endtask

   task automatic test_loads();
      send_cmd(mta_pkg::FUNC_LOAD_CUR, 4'd0, S32_MAX);
      send_cmd(mta_pkg::FUNC_LOAD_CUR, 4'd15, S32_MIN);
      send_cmd(mta_pkg::FUNC_LOAD_OPD, 4'd0, S32_MAX);
      send_cmd(mta_pkg::FUNC_LOAD_OPD, 4'd15, S32_MIN);
      send_cmd(mta_pkg::FUNC_LOAD_CUR, 4'd5, 32'sh0002_8000);
      send_cmd(mta_pkg::FUNC_READ);
      drain();
   endtask

   task automatic test_multiply();
      send_cmd(mta_pkg::FUNC_LOAD_OPD, 4'd5, ONE_Q);
      send_cmd(mta_pkg::FUNC_LOAD_OPD, 4'd10, -ONE_Q);
      send_cmd(mta_pkg::FUNC_MUL);
      send_cmd(mta_pkg::FUNC_LOAD_CUR, 4'd1, -32'sd3);
      send_cmd(mta_pkg::FUNC_LOAD_OPD, 4'd4, 32'sd1);
      send_cmd(mta_pkg::FUNC_MUL);
      drain();
   endtask

   task automatic test_translate_scale();
      send_cmd(mta_pkg::FUNC_TRANSLATE, 4'd0, 32'sd0, S32_MAX, S32_MIN, 32'sh0001_8000);
      send_cmd(mta_pkg::FUNC_SCALE, 4'd0, 32'sd0, S32_MIN, S32_MAX, -32'sd1);
      send_cmd(mta_pkg::FUNC_SCALE, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_cmd(mta_pkg::FUNC_TRANSLATE, 4'd0, 32'sd0, -32'sd1, 32'sd1, S32_MAX);
      drain();
   endtask

   task automatic test_spare_codes();
      send_cmd(FUNC_SPARE6, 4'hf, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
      send_cmd(FUNC_SPARE7, 4'hf, S32_MAX, S32_MIN, S32_MIN, S32_MIN);
      send_cmd(mta_pkg::FUNC_READ);
      drain();
   endtask

   task automatic test_random(input int n_items, input int idle, input int stall);
      int pick;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 30)
            send_cmd(mta_pkg::FUNC_LOAD_CUR, 4'($urandom), rand_fixed());
         else if (pick < 60)
            send_cmd(mta_pkg::FUNC_LOAD_OPD, 4'($urandom), rand_fixed());
         else if (pick < 72)
            send_cmd(mta_pkg::FUNC_MUL);
         else if (pick < 82)
            send_cmd(mta_pkg::FUNC_TRANSLATE, 4'($urandom), $urandom,
                     rand_fixed(), rand_fixed(), rand_fixed());
         else if (pick < 92)
            send_cmd(mta_pkg::FUNC_SCALE, 4'($urandom), $urandom,
                     rand_fixed(), rand_fixed(), rand_fixed());
         else if (pick < 97)
            send_cmd(mta_pkg::FUNC_READ, 4'($urandom), $urandom);
         else
            send_cmd($urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7, 4'($urandom),
                     $urandom, $urandom, $urandom, $urandom);
      end
      drain();
   endtask

   initial begin
      foreach (cur_mat[i]) cur_mat[i] = (i % 5 == 0) ? ONE_Q : '0;
      foreach (opd_mat[i]) opd_mat[i] = '0;
      req_bus.valid = 1'b0;
      req_bus.func = mta_pkg::FUNC_READ;
      req_bus.index = '0;
      req_bus.value = '0;
      req_bus.vec_x = '0;
      req_bus.vec_y = '0;
      req_bus.vec_z = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_loads();
      test_multiply();
      test_translate_scale();
      test_spare_codes();
      test_random(50, 0, 0);
      test_random(50, 86, 0);
      test_random(50, 0, 86);
      test_random(50, 38, 38);

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
